// ===== hw/rtl/tts_pkg.sv =====
// Shared types and constants for the triangle to trapezoid splitter.
`default_nettype none

package tts_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [1:0]                   vidx_t;

  localparam vidx_t VTX_A = 2'd0;
  localparam vidx_t VTX_B = 2'd1;
  localparam vidx_t VTX_C = 2'd2;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by_coord;
    coord_t cx;
    coord_t cy;
  } tri_in_t;

  typedef struct packed {
    coord_t top_y;
    coord_t bottom_y;
    vidx_t  left_from;
    vidx_t  left_to;
    vidx_t  right_from;
    vidx_t  right_to;
    logic   is_last;
  } trap_t;

  // sign of the cross product of the vertices in input order
  typedef struct packed {
    logic zero;
    logic neg;
  } crs_t;

  // vertex order by y plus the flat-edge tests
  typedef struct packed {
    vidx_t  id0;
    vidx_t  id1;
    vidx_t  id2;
    logic   odd;
    coord_t y0;
    coord_t y1;
    coord_t y2;
    logic   flat_top;
    logic   flat_bot;
    logic   top_swap;
    logic   bot_swap;
  } ord_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tts_cross.sv =====
// Three-stage cross product sign: differences, products, subtract.
`default_nettype none

module tts_cross (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire tts_pkg::tri_in_t vin,
  output tts_pkg::crs_t        crs
);

  tts_pkg::diff_t d1, d2, d3, d4;
  tts_pkg::prod_t p, q;
  tts_pkg::prod_t delta;

  assign delta = p - q;

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= {vin.bx[tts_pkg::COORD_BITS-1], vin.bx}
          - {vin.ax[tts_pkg::COORD_BITS-1], vin.ax};
      d2 <= {vin.cy[tts_pkg::COORD_BITS-1], vin.cy}
          - {vin.ay[tts_pkg::COORD_BITS-1], vin.ay};
      d3 <= {vin.cx[tts_pkg::COORD_BITS-1], vin.cx}
          - {vin.ax[tts_pkg::COORD_BITS-1], vin.ax};
      d4 <= {vin.by_coord[tts_pkg::COORD_BITS-1], vin.by_coord}
          - {vin.ay[tts_pkg::COORD_BITS-1], vin.ay};
      p <= d1 * d2;
      q <= d3 * d4;
      crs.zero <= (delta == '0);
      crs.neg  <= delta[tts_pkg::PROD_BITS-1];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_order.sv =====
// Three-stage vertex ordering: capture, stable y sort, flat-edge tests.
`default_nettype none

module tts_order (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             accept,
  input  wire tts_pkg::tri_in_t vin,
  output logic                  ord_valid,
  output tts_pkg::ord_t         ord
);

  tts_pkg::tri_in_t v1;
  logic             valid1, valid2;

  tts_pkg::vidx_t   id0_s, id1_s, id2_s;
  logic             odd_s;
  tts_pkg::vidx_t   sid0, sid1, sid2;
  logic             sodd;
  tts_pkg::coord_t  sx0, sx1, sx2, sy0, sy1, sy2;

  function automatic tts_pkg::coord_t y_of(tts_pkg::vidx_t i, tts_pkg::tri_in_t v);
    case (i)
      tts_pkg::VTX_A: y_of = v.ay;
      tts_pkg::VTX_B: y_of = v.by_coord;
      default:        y_of = v.cy;
    endcase
  endfunction

  function automatic tts_pkg::coord_t x_of(tts_pkg::vidx_t i, tts_pkg::tri_in_t v);
    case (i)
      tts_pkg::VTX_A: x_of = v.ax;
      tts_pkg::VTX_B: x_of = v.bx;
      default:        x_of = v.cx;
    endcase
  endfunction

  // stable compare-swaps (0,1), (0,2), (1,2) on strictly greater y
  always_comb begin
    tts_pkg::vidx_t t;
    t     = tts_pkg::VTX_A;
    id0_s = tts_pkg::VTX_A;
    id1_s = tts_pkg::VTX_B;
    id2_s = tts_pkg::VTX_C;
    odd_s = 1'b0;
    if ($signed(y_of(id0_s, v1)) > $signed(y_of(id1_s, v1))) begin
      t = id0_s; id0_s = id1_s; id1_s = t; odd_s = ~odd_s;
    end
    if ($signed(y_of(id0_s, v1)) > $signed(y_of(id2_s, v1))) begin
      t = id0_s; id0_s = id2_s; id2_s = t; odd_s = ~odd_s;
    end
    if ($signed(y_of(id1_s, v1)) > $signed(y_of(id2_s, v1))) begin
      t = id1_s; id1_s = id2_s; id2_s = t; odd_s = ~odd_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      ord_valid <= 1'b0;
    end else if (en) begin
      valid1    <= accept;
      valid2    <= valid1;
      ord_valid <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1   <= vin;
      sid0 <= id0_s;
      sid1 <= id1_s;
      sid2 <= id2_s;
      sodd <= odd_s;
      sx0  <= x_of(id0_s, v1);
      sx1  <= x_of(id1_s, v1);
      sx2  <= x_of(id2_s, v1);
      sy0  <= y_of(id0_s, v1);
      sy1  <= y_of(id1_s, v1);
      sy2  <= y_of(id2_s, v1);
      ord.id0      <= sid0;
      ord.id1      <= sid1;
      ord.id2      <= sid2;
      ord.odd      <= sodd;
      ord.y0       <= sy0;
      ord.y1       <= sy1;
      ord.y2       <= sy2;
      ord.flat_top <= (sy0 == sy1);
      ord.flat_bot <= (sy1 == sy2);
      ord.top_swap <= ($signed(sx0) > $signed(sx1));
      ord.bot_swap <= ($signed(sx1) > $signed(sx2));
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tts_emit.sv =====
// Trapezoid decode stage and output sequencer for one or two results.
`default_nettype none

module tts_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire tts_pkg::ord_t ord,
  input  wire tts_pkg::crs_t crs,
  output logic               stall,
  output logic               strobe,
  output tts_pkg::trap_t     trap
);

  logic           valid4;
  logic           has_any, two;
  logic           phase;
  tts_pkg::trap_t res0, res1;

  logic           any_next, two_next;
  tts_pkg::trap_t res0_next, res1_next;

  always_comb begin
    tts_pkg::vidx_t a, b;
    any_next  = 1'b0;
    two_next  = 1'b0;
    res0_next = '0;
    res1_next = '0;
    a = ord.id0;
    b = ord.id1;
    if (crs.zero) begin
      any_next = 1'b0;
    end else if (ord.flat_top) begin
      any_next = 1'b1;
      a = ord.top_swap ? ord.id1 : ord.id0;
      b = ord.top_swap ? ord.id0 : ord.id1;
      res0_next = '{ord.y0, ord.y2, a, ord.id2, b, ord.id2, 1'b1};
    end else if (ord.flat_bot) begin
      any_next = 1'b1;
      a = ord.bot_swap ? ord.id2 : ord.id1;
      b = ord.bot_swap ? ord.id1 : ord.id2;
      res0_next = '{ord.y0, ord.y2, ord.id0, a, ord.id0, b, 1'b1};
    end else begin
      any_next = 1'b1;
      two_next = 1'b1;
      // sorted-order cross sign is the input-order sign flipped by an odd sort
      if (crs.neg ^ ord.odd) begin
        res0_next = '{ord.y0, ord.y1, ord.id0, ord.id1, ord.id0, ord.id2, 1'b0};
        res1_next = '{ord.y1, ord.y2, ord.id1, ord.id2, ord.id0, ord.id2, 1'b1};
      end else begin
        res0_next = '{ord.y0, ord.y1, ord.id0, ord.id2, ord.id0, ord.id1, 1'b0};
        res1_next = '{ord.y1, ord.y2, ord.id0, ord.id2, ord.id1, ord.id2, 1'b1};
      end
    end
  end

  assign stall = valid4 & two & ~phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      phase  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= valid4 & has_any;
      phase  <= stall;
      if (!stall) begin
        valid4 <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    trap <= phase ? res1 : res0;
    if (!stall) begin
      has_any <= any_next;
      two     <= two_next;
      res0    <= res0_next;
      res1    <= res1_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_trapezoid_split.sv =====
// Top level: splits a triangle into one or two trapezoids.
//
//   channel   ports                  direction  request
//   triangle  start, busy, vertices  in         start & !busy
//   result    strobe, trap           out        strobe, one cycle each
//
// Five register stages from accept to strobe (diffs, products/sort,
// sign/flat tests, decode, output register).
// A triangle giving zero or one trapezoid never holds the pipeline;
// one giving two holds the whole pipeline at the decode stage while its
// first trapezoid goes to the output register, which is when busy is high.
// rst (synchronous) empties every stage; the receiver cannot stall.
`default_nettype none

module triangle_trapezoid_split (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tts_pkg::tri_in_t vertices,
  output logic                  strobe,
  output tts_pkg::trap_t        trap
);

  logic          stall;
  logic          en;
  logic          accept;
  logic          ord_valid;
  tts_pkg::ord_t ord;
  tts_pkg::crs_t crs;

  assign busy   = stall;
  assign en     = ~stall;
  assign accept = start & ~busy;

  tts_cross u_cross (
    .clk (clk),
    .en  (en),
    .vin (vertices),
    .crs (crs)
  );

  tts_order u_order (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .accept    (accept),
    .vin       (vertices),
    .ord_valid (ord_valid),
    .ord       (ord)
  );

  tts_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ord_valid),
    .ord      (ord),
    .crs      (crs),
    .stall    (stall),
    .strobe   (strobe),
    .trap     (trap)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the triangle to trapezoid splitter.
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_TRIS    = 830;
  localparam int STEADY_TRIS    = 250;
  localparam int DRAIN_CYCLES   = 12;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  tts_pkg::tri_in_t vertices = '0;
  logic             strobe;
  tts_pkg::trap_t   trap;

  tts_pkg::trap_t pending_traps[$];
  int    fail_count = 0;
  int    stall_cycles = 0;
  bit    steady = 1'b0;

  triangle_trapezoid_split i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .vertices (vertices),
    .strobe   (strobe),
    .trap     (trap)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic tts_pkg::tri_in_t mk_tri(int x0, int y0, int x1, int y1,
                                              int x2, int y2);
    tts_pkg::tri_in_t t;
    t.ax       = tts_pkg::coord_t'(x0);
    t.ay       = tts_pkg::coord_t'(y0);
    t.bx       = tts_pkg::coord_t'(x1);
    t.by_coord = tts_pkg::coord_t'(y1);
    t.cx       = tts_pkg::coord_t'(x2);
    t.cy       = tts_pkg::coord_t'(y2);
    return t;
  endfunction

  function automatic tts_pkg::trap_t mk_trap(longint top, longint bot,
                                             tts_pkg::vidx_t lf, tts_pkg::vidx_t lt,
                                             tts_pkg::vidx_t rf, tts_pkg::vidx_t rt,
                                             logic last);
    tts_pkg::trap_t r;
    r.top_y      = tts_pkg::coord_t'(top);
    r.bottom_y   = tts_pkg::coord_t'(bot);
    r.left_from  = lf;
    r.left_to    = lt;
    r.right_from = rf;
    r.right_to   = rt;
    r.is_last    = last;
    return r;
  endfunction

  // sign of a*b - c*d; operands are 17-bit diffs, so 64 bits is exact
  function automatic int cross_sign(longint a, longint b, longint c, longint d);
    longint p;
    p = a * b - c * d;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  // returns the number of trapezoids; first/second hold them in output order
  function automatic int split_triangle(input tts_pkg::tri_in_t t,
                                        output tts_pkg::trap_t first,
                                        output tts_pkg::trap_t second);
    longint         x[3];
    longint         y[3];
    tts_pkg::vidx_t ord[3];
    tts_pkg::vidx_t v1, v2, v3, sw;
    first  = '0;
    second = '0;
    x[0] = t.ax;  y[0] = t.ay;
    x[1] = t.bx;  y[1] = t.by_coord;
    x[2] = t.cx;  y[2] = t.cy;
    if (cross_sign(x[1] - x[0], y[2] - y[0], x[2] - x[0], y[1] - y[0]) == 0)
      return 0;
    ord[0] = tts_pkg::VTX_A;
    ord[1] = tts_pkg::VTX_B;
    ord[2] = tts_pkg::VTX_C;
    // stable compare-swaps: (0,1), (0,2), (1,2), swap only on strictly greater y
    if (y[ord[0]] > y[ord[1]]) begin sw = ord[0]; ord[0] = ord[1]; ord[1] = sw; end
    if (y[ord[0]] > y[ord[2]]) begin sw = ord[0]; ord[0] = ord[2]; ord[2] = sw; end
    if (y[ord[1]] > y[ord[2]]) begin sw = ord[1]; ord[1] = ord[2]; ord[2] = sw; end
    v1 = ord[0];
    v2 = ord[1];
    v3 = ord[2];
    if (y[v1] == y[v2]) begin
      if (x[v1] > x[v2]) begin sw = v1; v1 = v2; v2 = sw; end
      first = mk_trap(y[v1], y[v3], v1, v3, v2, v3, 1'b1);
      return 1;
    end
    if (y[v2] == y[v3]) begin
      if (x[v2] > x[v3]) begin sw = v2; v2 = v3; v3 = sw; end
      first = mk_trap(y[v1], y[v3], v1, v2, v1, v3, 1'b1);
      return 1;
    end
    // middle vertex left of the long edge puts the short edges on the left
    if (cross_sign(x[v2] - x[v1], y[v3] - y[v1], x[v3] - x[v1], y[v2] - y[v1]) < 0) begin
      first  = mk_trap(y[v1], y[v2], v1, v2, v1, v3, 1'b0);
      second = mk_trap(y[v2], y[v3], v2, v3, v1, v3, 1'b1);
    end else begin
      first  = mk_trap(y[v1], y[v2], v1, v3, v1, v2, 1'b0);
      second = mk_trap(y[v2], y[v3], v1, v3, v2, v3, 1'b1);
    end
    return 2;
  endfunction

  task automatic send_triangle(input tts_pkg::tri_in_t t);
    tts_pkg::trap_t first, second;
    int             n;
    if (!steady && $urandom_range(99) < 7) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    vertices <= t;
    do @(posedge clk); while (busy !== 1'b0);
    n = split_triangle(t, first, second);
    if (n > 0) pending_traps.push_back(first);
    if (n > 1) pending_traps.push_back(second);
  endtask

  function automatic tts_pkg::coord_t rand_coord();
    return tts_pkg::coord_t'($urandom);
  endfunction

  function automatic tts_pkg::coord_t edge_coord();
    case ($urandom_range(4))
      0: return tts_pkg::coord_t'(-32768);
      1: return tts_pkg::coord_t'(32767);
      2: return tts_pkg::coord_t'(0);
      3: return tts_pkg::coord_t'(-1);
      default: return rand_coord();
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    tts_pkg::trap_t want;
    if (!rst && strobe === 1'b1) begin
      if (pending_traps.size() == 0) begin
        $error("trapezoid with none expected: %p", trap);
        fail_count++;
      end else begin
        want = pending_traps.pop_front();
        check_field("top_y", want.top_y, trap.top_y);
        check_field("bottom_y", want.bottom_y, trap.bottom_y);
        check_field("left_from", want.left_from, trap.left_from);
        check_field("left_to", want.left_to, trap.left_to);
        check_field("right_from", want.right_from, trap.right_from);
        check_field("right_to", want.right_to, trap.right_to);
        check_field("is_last", want.is_last, trap.is_last);
      end
    end
  end

  // counts cycles where neither a request nor a trapezoid moves
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_degenerate();
    send_triangle(mk_tri(0, 0, 0, 0, 0, 0));
    send_triangle(mk_tri(-5, 3, 7, 3, 100, 3));
    send_triangle(mk_tri(0, 0, 1, 1, 2, 2));
    send_triangle(mk_tri(4, 4, 4, 4, 9, 1));
    send_triangle(mk_tri(-32768, -32768, 0, 0, 32767, 32767));
  endtask

  task automatic test_flat();
    send_triangle(mk_tri(0, 0, 10, 0, 5, 20));
    send_triangle(mk_tri(10, 0, 0, 0, 5, 20));
    send_triangle(mk_tri(10, 0, 5, 20, 0, 0));
    send_triangle(mk_tri(5, 0, 0, 20, 10, 20));
    send_triangle(mk_tri(5, 0, 10, 20, 0, 20));
    send_triangle(mk_tri(0, 20, 5, 0, 10, 20));
  endtask

  task automatic test_general();
    send_triangle(mk_tri(0, 0, -10, 10, 5, 20));
    send_triangle(mk_tri(0, 0, 10, 10, 5, 20));
    send_triangle(mk_tri(5, 20, 10, 10, 0, 0));
    send_triangle(mk_tri(-10, 10, 5, 20, 0, 0));
    send_triangle(mk_tri(-300, -7, -250, -90, -400, -33));
    send_triangle(mk_tri(-400, -33, -300, -7, -250, -90));
  endtask

  task automatic test_extremes();
    send_triangle(mk_tri(-32768, -32768, 32767, -32768, 0, 32767));
    send_triangle(mk_tri(-32768, 32767, 32767, -32768, 32767, 32767));
    send_triangle(mk_tri(-32768, -32768, 32767, 0, -32768, 32767));
    send_triangle(mk_tri(32767, -32768, -32768, 0, 32767, 32767));
    send_triangle(mk_tri(-32768, -32768, 32767, 32766, 32767, 32767));
    send_triangle(mk_tri(-1, -1, 32767, -32768, -32768, 32767));
  endtask

  // mix: full range, tiny range (ties), flat edges, collinear, extreme values
  task automatic test_random_mix();
    tts_pkg::coord_t px[3], py[3];
    int              bx, by, dx, dy, k, apex;
    for (int i = 0; i < RANDOM_TRIS; i++) begin
      steady = (i < STEADY_TRIS);
      k = $urandom_range(99);
      if (k < 35) begin
        for (int j = 0; j < 3; j++) begin px[j] = rand_coord(); py[j] = rand_coord(); end
      end else if (k < 55) begin
        for (int j = 0; j < 3; j++) begin
          px[j] = tts_pkg::coord_t'($urandom_range(16) - 8);
          py[j] = tts_pkg::coord_t'($urandom_range(16) - 8);
        end
      end else if (k < 70) begin
        apex = $urandom_range(2);
        by = $urandom_range(1) ? $urandom_range(16) - 8 : int'(rand_coord());
        for (int j = 0; j < 3; j++) begin
          px[j] = $urandom_range(1) ? tts_pkg::coord_t'($urandom_range(20) - 10)
                                    : rand_coord();
          py[j] = tts_pkg::coord_t'(by);
        end
        py[apex] = rand_coord();
        if (py[apex] == tts_pkg::coord_t'(by)) py[apex] = tts_pkg::coord_t'(by + 1);
      end else if (k < 80) begin
        bx = $urandom_range(20000) - 10000;
        by = $urandom_range(20000) - 10000;
        dx = $urandom_range(200) - 100;
        dy = $urandom_range(200) - 100;
        for (int j = 0; j < 3; j++) begin
          apex = $urandom_range(100) - 50;
          px[j] = tts_pkg::coord_t'(bx + apex * dx);
          py[j] = tts_pkg::coord_t'(by + apex * dy);
        end
      end else begin
        for (int j = 0; j < 3; j++) begin px[j] = edge_coord(); py[j] = edge_coord(); end
      end
      send_triangle(mk_tri(px[0], py[0], px[1], py[1], px[2], py[2]));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_degenerate();
    test_flat();
    test_general();
    test_extremes();
    test_random_mix();
    start <= 1'b0;
    while (pending_traps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
